// ===== rtl/i2cm_pkg.sv =====
`default_nettype none
package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_SEND  = 3'd2,
    OP_WACK  = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [16:0] {
    PH_IDLE    = 17'h00001,
    PH_ST1     = 17'h00002,
    PH_ST2     = 17'h00004,
    PH_SP1     = 17'h00008,
    PH_SP2     = 17'h00010,
    PH_WA1     = 17'h00020,
    PH_WA2     = 17'h00040,
    PH_WAP     = 17'h00080,
    PH_SB_LEAD = 17'h00100,
    PH_SB_SET  = 17'h00200,
    PH_SB_HI   = 17'h00400,
    PH_SB_LO   = 17'h00800,
    PH_SB_TAIL = 17'h01000,
    PH_RB_LO   = 17'h02000,
    PH_RB_HI   = 17'h04000,
    PH_RB_A1   = 17'h08000,
    PH_RB_A2   = 17'h10000
  } phase_t;

  localparam int unsigned DLY_W = 11;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       give_ack;
    logic       sda;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       fail;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/i2cm_front.sv =====
`default_nettype none
module i2cm_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire              in_command_valid,
  input  wire        [2:0] in_operation,
  input  wire        [7:0] in_tx_byte,
  input  wire              in_give_ack,
  input  wire              in_sda_sample,
  output logic             q_valid,
  output i2cm_pkg::tick_t  q_data,
  input  wire              q_pop
);
  import i2cm_pkg::*;

  // Two-entry queue of ticks.
  tick_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{cmd_valid: in_command_valid, op: in_operation,
                       tx_byte: in_tx_byte, give_ack: in_give_ack, sda: in_sda_sample};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/i2cm_back.sv =====
`default_nettype none
module i2cm_back (
  input  wire             clk,
  input  wire             rst_n,
  input  wire       [7:0] tpu,
  input  wire       [7:0] limit,
  input  wire             q_valid,
  input  i2cm_pkg::tick_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire             out_stall,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  phase_t           ph_r, ph_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [7:0]       sh_r, sh_nxt;
  logic [DLY_W-1:0] dly_r, dly_nxt, dec;
  logic [7:0]       poll_r, poll_nxt;
  logic             ackc_r, ackc_nxt;
  logic             scl_r, scl_nxt, sda_r, sda_nxt, drv_r, drv_nxt;
  logic [7:0]       rx_r, rx_nxt;
  logic             fail_r, fail_nxt, done_nxt;
  logic             ov_r;
  res_t             res_r;
  logic [7:0]       t;
  logic [DLY_W-1:0] d1, d2, d3, d4, d5;
  logic [8:0]       pnext;
  logic             sda;

  assign t  = (tpu == 8'd0) ? 8'd1 : tpu;
  assign d1 = {3'd0, t};
  assign d2 = {2'd0, t, 1'b0};
  assign d4 = {1'b0, t, 2'b0};
  assign d3 = d2 + d1;
  assign d5 = d4 + d1;

  assign q_pop     = q_valid && (!ov_r || !out_stall);
  assign out_valid = ov_r;
  assign res       = res_r;
  assign sda       = q_data.sda;

  always_comb begin
    ph_nxt = ph_r; bit_nxt = bit_r; sh_nxt = sh_r; dly_nxt = dly_r;
    poll_nxt = poll_r; ackc_nxt = ackc_r; scl_nxt = scl_r; sda_nxt = sda_r;
    drv_nxt = drv_r; rx_nxt = rx_r; fail_nxt = fail_r; done_nxt = 1'b0;
    pnext = {1'b0, poll_r} + 9'd1;
    dec = (dly_r != '0) ? dly_r - 1'b1 : dly_r;
    if (ph_r == PH_IDLE) begin
      if (q_data.cmd_valid) begin
        case (q_data.op)
          OP_START: begin
            bit_nxt = '0; drv_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1;
            dly_nxt = d4; ph_nxt = PH_ST1;
          end
          OP_STOP: begin
            bit_nxt = '0; drv_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
            dly_nxt = d4; ph_nxt = PH_SP1;
          end
          OP_SEND: begin
            bit_nxt = '0; drv_nxt = 1'b1; scl_nxt = 1'b0; sh_nxt = q_data.tx_byte;
            dly_nxt = d2; ph_nxt = PH_SB_LEAD;
          end
          OP_WACK: begin
            bit_nxt = '0; fail_nxt = 1'b0; poll_nxt = '0; drv_nxt = 1'b0;
            sda_nxt = 1'b1; dly_nxt = d1; ph_nxt = PH_WA1;
          end
          OP_READ: begin
            bit_nxt = '0; drv_nxt = 1'b0; sh_nxt = '0; ackc_nxt = q_data.give_ack;
            scl_nxt = 1'b0; dly_nxt = d2; ph_nxt = PH_RB_LO;
          end
          default: begin
            bit_nxt = '0;
          end
        endcase
      end
    end else if (ph_r == PH_WAP || (ph_r == PH_WA2 && dec == '0)) begin
      dly_nxt = dec;
      if (ph_r == PH_WAP) dly_nxt = dly_r;
      if (!sda) begin
        scl_nxt = 1'b0; ph_nxt = PH_IDLE; done_nxt = 1'b1;
      end else if (pnext > {1'b0, limit}) begin
        fail_nxt = 1'b1; drv_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
        dly_nxt = d4; ph_nxt = PH_SP1;
      end else begin
        poll_nxt = pnext[7:0]; ph_nxt = PH_WAP;
      end
    end else begin
      dly_nxt = dec;
      if (dec == '0) begin
        case (ph_r)
          PH_ST1: begin sda_nxt = 1'b0; dly_nxt = d4; ph_nxt = PH_ST2; end
          PH_ST2: begin scl_nxt = 1'b0; ph_nxt = PH_IDLE; done_nxt = 1'b1; end
          PH_SP1: begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; dly_nxt = d4; ph_nxt = PH_SP2;
          end
          PH_SP2: begin ph_nxt = PH_IDLE; done_nxt = 1'b1; end
          PH_WA1: begin scl_nxt = 1'b1; dly_nxt = d1; ph_nxt = PH_WA2; end
          PH_SB_LEAD: begin
            sda_nxt = sh_r[7]; sh_nxt = {sh_r[6:0], 1'b0};
            dly_nxt = d2; ph_nxt = PH_SB_SET;
          end
          PH_SB_SET: begin scl_nxt = 1'b1; dly_nxt = d5; ph_nxt = PH_SB_HI; end
          PH_SB_HI: begin scl_nxt = 1'b0; dly_nxt = d3; ph_nxt = PH_SB_LO; end
          PH_SB_LO: begin
            bit_nxt = bit_r + 4'd1;
            if (bit_nxt < 4'd8) begin
              sda_nxt = sh_r[7]; sh_nxt = {sh_r[6:0], 1'b0};
              dly_nxt = d2; ph_nxt = PH_SB_SET;
            end else begin
              sda_nxt = 1'b1; dly_nxt = d1; ph_nxt = PH_SB_TAIL;
            end
          end
          PH_SB_TAIL: begin ph_nxt = PH_IDLE; done_nxt = 1'b1; end
          PH_RB_LO: begin scl_nxt = 1'b1; dly_nxt = d1; ph_nxt = PH_RB_HI; end
          PH_RB_HI: begin
            sh_nxt = {sh_r[6:0], sda};
            bit_nxt = bit_r + 4'd1;
            if (bit_nxt < 4'd8) begin
              scl_nxt = 1'b0; dly_nxt = d2; ph_nxt = PH_RB_LO;
            end else begin
              scl_nxt = 1'b0; drv_nxt = 1'b1; sda_nxt = !ackc_r;
              dly_nxt = d2; ph_nxt = PH_RB_A1;
            end
          end
          PH_RB_A1: begin scl_nxt = 1'b1; dly_nxt = d2; ph_nxt = PH_RB_A2; end
          PH_RB_A2: begin
            scl_nxt = 1'b0; rx_nxt = sh_r; ph_nxt = PH_IDLE; done_nxt = 1'b1;
          end
          default: ph_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; bit_r <= '0; sh_r <= '0; dly_r <= '0; poll_r <= '0;
      ackc_r <= 1'b0; scl_r <= 1'b1; sda_r <= 1'b1; drv_r <= 1'b1;
      rx_r <= '0; fail_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (q_pop) begin
        ph_r <= ph_nxt; bit_r <= bit_nxt; sh_r <= sh_nxt; dly_r <= dly_nxt;
        poll_r <= poll_nxt; ackc_r <= ackc_nxt; scl_r <= scl_nxt;
        sda_r <= sda_nxt; drv_r <= drv_nxt; rx_r <= rx_nxt; fail_r <= fail_nxt;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= '{scl: scl_nxt, sda: sda_nxt, drv: drv_nxt,
                 busy: (ph_nxt != PH_IDLE), done: done_nxt, rx: rx_nxt, fail: fail_nxt};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/i2c_bit_level_master_core.sv =====
// A tick accepted into the two-entry queue has its result registered in the result register
// once the back end pops it from the queue.
// Throughput: one tick per clock while neither side stalls; the sequencer updates its state once per tick.
// A two-entry tick queue decouples input stalls from output stalls.
// Reset is synchronous, active low: idle, SCL and SDA high and driven,
// prescaler 1, ACK timeout limit 254.
`default_nettype none
module i2c_bit_level_master_core (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       cfg_we,
  input  wire [0:0] cfg_index,
  input  wire [7:0] cfg_wdata,
  input  wire       in_valid,
  output logic      in_stall,
  input  wire       in_command_valid,
  input  wire [2:0] in_operation,
  input  wire [7:0] in_tx_byte,
  input  wire       in_give_ack,
  input  wire       in_sda_sample,
  output logic      out_valid,
  input  wire       out_stall,
  output logic      out_scl_level,
  output logic      out_sda_level,
  output logic      out_sda_driving,
  output logic      out_busy_res,
  output logic      out_command_done,
  output logic [7:0] out_rx_byte,
  output logic      out_ack_failed
);
  import i2cm_pkg::*;

  logic [7:0] tpu_r, lim_r;
  logic       q_valid, q_pop;
  tick_t      q_data;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= 8'd1;
      lim_r <= 8'd254;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) tpu_r <= cfg_wdata;
      else                   lim_r <= cfg_wdata;
    end
  end

  i2cm_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command_valid, .in_operation,
    .in_tx_byte, .in_give_ack, .in_sda_sample, .q_valid, .q_data, .q_pop
  );

  i2cm_back u_back (
    .clk, .rst_n, .tpu(tpu_r), .limit(lim_r), .q_valid, .q_data, .q_pop,
    .out_valid, .out_stall, .res
  );

  assign out_scl_level    = res.scl;
  assign out_sda_level    = res.sda;
  assign out_sda_driving  = res.drv;
  assign out_busy_res     = res.busy;
  assign out_command_done = res.done;
  assign out_rx_byte      = res.rx;
  assign out_ack_failed   = res.fail;
endmodule
`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
`default_nettype none
module i2cm_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_stall,
  input wire       out_busy_res,
  input wire       out_command_done,
  input wire       out_sda_driving,
  input wire [7:0] out_rx_byte
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rx_byte) && $stable(out_sda_driving))
    else $error("stalled item changed");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_done |-> !out_busy_res)
    else $error("done while busy");
  a_reset_pins: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item after reset");
endmodule

bind i2c_bit_level_master_core i2cm_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_busy_res, .out_command_done,
  .out_sda_driving, .out_rx_byte
);
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;
  import i2cm_pkg::*;

  localparam int NROWS = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    tick_t t;
    bit    has_exp;
    res_t  e;
  } item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_command_valid = 1'b0;
  logic [2:0] in_operation = '0;
  logic [7:0] in_tx_byte = '0;
  logic       in_give_ack = 1'b0;
  logic       in_sda_sample = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_sda_driving;
  logic       out_busy_res;
  logic       out_command_done;
  logic [7:0] out_rx_byte;
  logic       out_ack_failed;

  i2c_bit_level_master_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command_valid(in_command_valid), .in_operation(in_operation),
    .in_tx_byte(in_tx_byte), .in_give_ack(in_give_ack), .in_sda_sample(in_sda_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_scl_level(out_scl_level), .out_sda_level(out_sda_level),
    .out_sda_driving(out_sda_driving), .out_busy_res(out_busy_res),
    .out_command_done(out_command_done), .out_rx_byte(out_rx_byte),
    .out_ack_failed(out_ack_failed)
  );

  always #5 clk = ~clk;

  // Bus sequencer model.
  phase_t     m_phase;
  logic [3:0] m_bit;
  logic [7:0] m_shift;
  logic [10:0] m_dly;
  logic [7:0] m_poll;
  logic       m_ackc, m_scl, m_sda, m_drv, m_done, m_fail;
  logic [7:0] m_rx;
  logic [7:0] m_tpu, m_lim;

  task load_delay(input int us);
    int t;
    t = (m_tpu == 0) ? 1 : m_tpu;
    m_dly = 11'(us * t);
  endtask

  task end_cmd();
    m_phase = PH_IDLE;
    m_done = 1'b1;
  endtask

  task begin_stop();
    m_drv = 1'b1; m_scl = 1'b0; m_sda = 1'b0;
    load_delay(4);
    m_phase = PH_SP1;
  endtask

  task present_bit();
    m_sda = m_shift[7];
    m_shift = m_shift << 1;
    load_delay(2);
    m_phase = PH_SB_SET;
  endtask

  task begin_rx_bit();
    m_scl = 1'b0;
    load_delay(2);
    m_phase = PH_RB_LO;
  endtask

  task poll_sda(input logic sda);
    int nxt;
    if (!sda) begin
      m_scl = 1'b0;
      end_cmd();
    end else begin
      nxt = m_poll + 1;
      if (nxt > m_lim) begin
        m_fail = 1'b1;
        begin_stop();
      end else begin
        m_poll = 8'(nxt);
        m_phase = PH_WAP;
      end
    end
  endtask

  task advance_phase(input logic sda);
    case (m_phase)
      PH_ST1: begin m_sda = 1'b0; load_delay(4); m_phase = PH_ST2; end
      PH_ST2: begin m_scl = 1'b0; end_cmd(); end
      PH_SP1: begin m_scl = 1'b1; m_sda = 1'b1; load_delay(4); m_phase = PH_SP2; end
      PH_SP2: end_cmd();
      PH_WA1: begin m_scl = 1'b1; load_delay(1); m_phase = PH_WA2; end
      PH_WA2: poll_sda(sda);
      PH_SB_LEAD: present_bit();
      PH_SB_SET: begin m_scl = 1'b1; load_delay(5); m_phase = PH_SB_HI; end
      PH_SB_HI: begin m_scl = 1'b0; load_delay(3); m_phase = PH_SB_LO; end
      PH_SB_LO: begin
        m_bit = m_bit + 4'd1;
        if (m_bit < 8) begin
          present_bit();
        end else begin
          m_sda = 1'b1;
          load_delay(1);
          m_phase = PH_SB_TAIL;
        end
      end
      PH_SB_TAIL: end_cmd();
      PH_RB_LO: begin m_scl = 1'b1; load_delay(1); m_phase = PH_RB_HI; end
      PH_RB_HI: begin
        m_shift = {m_shift[6:0], sda};
        m_bit = m_bit + 4'd1;
        if (m_bit < 8) begin
          begin_rx_bit();
        end else begin
          m_scl = 1'b0; m_drv = 1'b1;
          m_sda = ~m_ackc;
          load_delay(2);
          m_phase = PH_RB_A1;
        end
      end
      PH_RB_A1: begin m_scl = 1'b1; load_delay(2); m_phase = PH_RB_A2; end
      PH_RB_A2: begin m_scl = 1'b0; m_rx = m_shift; end_cmd(); end
      default: m_phase = PH_IDLE;
    endcase
  endtask

  task start_cmd(input tick_t t);
    m_bit = '0;
    case (t.op)
      OP_START: begin
        m_drv = 1'b1; m_sda = 1'b1; m_scl = 1'b1;
        load_delay(4); m_phase = PH_ST1;
      end
      OP_STOP: begin_stop();
      OP_SEND: begin
        m_drv = 1'b1; m_scl = 1'b0; m_shift = t.tx_byte;
        load_delay(2); m_phase = PH_SB_LEAD;
      end
      OP_WACK: begin
        m_fail = 1'b0; m_poll = '0; m_drv = 1'b0; m_sda = 1'b1;
        load_delay(1); m_phase = PH_WA1;
      end
      OP_READ: begin
        m_drv = 1'b0; m_shift = '0; m_ackc = t.give_ack;
        begin_rx_bit();
      end
      default: ;
    endcase
  endtask

  task predict_tick(input tick_t t, output res_t r);
    m_done = 1'b0;
    if (m_phase == PH_IDLE) begin
      if (t.cmd_valid) start_cmd(t);
    end else if (m_phase == PH_WAP) begin
      poll_sda(t.sda);
    end else begin
      if (m_dly > 0) m_dly = m_dly - 11'd1;
      if (m_dly == 0) advance_phase(t.sda);
    end
    r = '{scl: m_scl, sda: m_sda, drv: m_drv, busy: (m_phase != PH_IDLE),
          done: m_done, rx: m_rx, fail: m_fail};
  endtask

  // Stimulus.
  item_t rows [NROWS];
  item_t cur;
  res_t  bus_q [$];
  int    dir_idx = 0;
  int    n_sent = 0;
  int    target = 0;
  int    gap = 0;
  bit    running = 1'b0;
  bit    stopped = 1'b1;
  bit    quiet = 1'b0;
  bit    hold = 1'b0;
  bit    did_hold = 1'b0;
  int    errors = 0;
  int    cycles = 0;

  function automatic item_t mk_row(bit cv, logic [2:0] op, logic [7:0] tx, bit ack, bit sda,
                                   bit has_exp, res_t e);
    item_t it;
    it.t = '{cmd_valid: cv, op: op, tx_byte: tx, give_ack: ack, sda: sda};
    it.has_exp = has_exp;
    it.e = e;
    return it;
  endfunction

  task make_item(output item_t it);
    bit waiting;
    it.has_exp = 1'b0;
    it.e = '0;
    if (dir_idx < NROWS) begin
      if (m_phase != PH_IDLE) begin
        it.t = rows[dir_idx-1].t;
      end else begin
        it = rows[dir_idx];
        dir_idx++;
      end
    end else begin
      waiting = (m_phase == PH_WA2) || (m_phase == PH_WAP);
      it.t.cmd_valid = (m_phase == PH_IDLE) ? ($urandom_range(0, 9) < 7) :
                                              1'($urandom_range(0, 1));
      it.t.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      it.t.tx_byte = 8'($urandom);
      it.t.give_ack = 1'($urandom_range(0, 1));
      it.t.sda = waiting ? ($urandom_range(0, 15) != 0) : 1'($urandom_range(0, 1));
    end
  endtask

  always @(posedge clk) begin
    res_t r;
    bit acc;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_bit_level_master_core: mismatch");
      $finish;
    end else if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      acc = in_valid && !in_stall;
      if (acc) begin
        predict_tick(cur.t, r);
        bus_q.push_back(cur.has_exp ? cur.e : r);
        n_sent++;
      end
      if (in_valid && !acc) begin
        stopped <= 1'b0;
      end else if (!running ||
                   (n_sent >= target && dir_idx >= NROWS && m_phase == PH_IDLE)) begin
        in_valid <= 1'b0;
        stopped <= 1'b1;
      end else begin
        stopped <= 1'b0;
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (hold) begin
          if (bus_q.size() == 0) hold = 1'b0;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (!quiet && dir_idx >= NROWS &&
                     ((!did_hold && n_sent > 250) || $urandom_range(0, 399) == 0)) begin
          hold = 1'b1;
          did_hold = 1'b1;
          in_valid <= 1'b0;
        end else begin
          make_item(cur);
          in_valid <= 1'b1;
          in_command_valid <= cur.t.cmd_valid;
          in_operation <= cur.t.op;
          in_tx_byte <= cur.t.tx_byte;
          in_give_ack <= cur.t.give_ack;
          in_sda_sample <= cur.t.sda;
        end
      end
    end
  end

  // Result side: stall bursts and comparison.
  int ostall = 0;
  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (bus_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item");
        end else begin
          e = bus_q.pop_front();
          if (out_scl_level !== e.scl || out_sda_level !== e.sda ||
              out_sda_driving !== e.drv || out_busy_res !== e.busy ||
              out_command_done !== e.done || out_rx_byte !== e.rx ||
              out_ack_failed !== e.fail) begin
            errors++;
            if (errors <= 10)
              $display({"result item differs: exp scl=%b sda=%b drv=%b busy=%b done=%b",
                        " rx=%h fail=%b, got scl=%b sda=%b drv=%b busy=%b done=%b rx=%h",
                        " fail=%b"},
                       e.scl, e.sda, e.drv, e.busy, e.done, e.rx, e.fail,
                       out_scl_level, out_sda_level, out_sda_driving, out_busy_res,
                       out_command_done, out_rx_byte, out_ack_failed);
          end
        end
      end
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (ostall > 0) begin
        ostall--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        ostall = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == 1'b0) m_tpu = val;
    else m_lim = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task run_phase(input logic [7:0] tpu, input logic [7:0] lim, input int count,
                 input bit no_idle);
    write_reg(1'b0, tpu);
    write_reg(1'b1, lim);
    @(posedge clk);
    quiet <= no_idle;
    target <= n_sent + count;
    running <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    while (!stopped) @(posedge clk);
    running <= 1'b0;
    while (bus_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    res_t idle_r, start_r, stop_r;
    idle_r  = '{scl: 1'b1, sda: 1'b1, drv: 1'b1, busy: 1'b0, done: 1'b0, rx: 8'h00,
                fail: 1'b0};
    start_r = '{scl: 1'b1, sda: 1'b1, drv: 1'b1, busy: 1'b1, done: 1'b0, rx: 8'h00,
                fail: 1'b0};
    stop_r  = '{scl: 1'b0, sda: 1'b0, drv: 1'b1, busy: 1'b1, done: 1'b0, rx: 8'h00,
                fail: 1'b0};
    rows[0]  = mk_row(1'b0, OP_START, 8'h00, 1'b0, 1'b1, 1'b1, idle_r);
    rows[1]  = mk_row(1'b1, 3'd5,     8'h00, 1'b0, 1'b1, 1'b1, idle_r);
    rows[2]  = mk_row(1'b1, 3'd6,     8'hFF, 1'b1, 1'b0, 1'b1, idle_r);
    rows[3]  = mk_row(1'b1, 3'd7,     8'h00, 1'b0, 1'b1, 1'b1, idle_r);
    rows[4]  = mk_row(1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1'b1, start_r);
    rows[5]  = mk_row(1'b1, OP_STOP,  8'h00, 1'b0, 1'b1, 1'b1, stop_r);
    rows[6]  = mk_row(1'b1, OP_SEND,  8'h00, 1'b0, 1'b0, 1'b0, idle_r);
    rows[7]  = mk_row(1'b1, OP_SEND,  8'hFF, 1'b1, 1'b1, 1'b0, idle_r);
    rows[8]  = mk_row(1'b1, OP_SEND,  8'hA5, 1'b0, 1'b1, 1'b0, idle_r);
    rows[9]  = mk_row(1'b1, OP_WACK,  8'h00, 1'b0, 1'b0, 1'b0, idle_r);
    rows[10] = mk_row(1'b1, OP_WACK,  8'hFF, 1'b1, 1'b1, 1'b0, idle_r);
    rows[11] = mk_row(1'b1, OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, idle_r);
    rows[12] = mk_row(1'b1, OP_READ,  8'hFF, 1'b0, 1'b0, 1'b0, idle_r);
    rows[13] = mk_row(1'b1, OP_READ,  8'h5A, 1'b1, 1'b0, 1'b0, idle_r);
    rows[14] = mk_row(1'b1, OP_WACK,  8'h00, 1'b0, 1'b0, 1'b0, idle_r);
    rows[15] = mk_row(1'b1, OP_STOP,  8'h00, 1'b1, 1'b1, 1'b0, idle_r);

    m_phase = PH_IDLE; m_bit = '0; m_shift = '0; m_dly = '0; m_poll = '0;
    m_ackc = 1'b0; m_scl = 1'b1; m_sda = 1'b1; m_drv = 1'b1; m_done = 1'b0;
    m_fail = 1'b0; m_rx = '0; m_tpu = 8'd1; m_lim = 8'd254;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_phase(8'd1, 8'd254, 100, 1'b0);
    run_phase(8'd1, 8'd0, 40, 1'b0);
    run_phase(8'd0, 8'd3, 40, 1'b0);
    run_phase(8'd2, 8'd20, 40, 1'b0);
    run_phase(8'd1, 8'd8, 40, 1'b1);

    if (errors == 0 && bus_q.size() == 0) begin
      $display("i2c_bit_level_master_core: match");
    end else begin
      $display("i2c_bit_level_master_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== i2c_bit_level_master_core.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_bit_level_master_core.sv
rtl/i2cm_checker.sv
verif/tb.sv
